// ----- src/assert_macros.svh -----
// Assertion helpers. They expect clk and rst_n to be visible where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define DEQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never be seen outside reset.
`define DEQ_NEVER(label, cond, msg) \
  `DEQ_ASSERT(label, !(cond), msg)

`endif

// ----- src/deq_pkg.sv -----
package deq_pkg;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_FIRST = 3'd4,
    REQ_PEEK_LAST  = 3'd5,
    REQ_WALK_FWD   = 3'd6,
    REQ_WALK_BWD   = 3'd7
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    OP_HOLD = 3'd0,
    OP_SHR  = 3'd1,
    OP_SHL  = 3'd2,
    OP_LOAD = 3'd3,
    OP_ROTL = 3'd4,
    OP_ROTR = 3'd5
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     in_occ;  // cell holds an element
    logic     is_tail; // cell holds the last element
    logic     is_cnt;  // first free cell
  } cell_ctl_t;

endpackage

// ----- src/deq_if.sv -----
interface deq_req_if #(
  parameter int DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            req_type;
  logic [DATA_WIDTH-1:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink (input valid, input req_type, input push_value, output ready);
endinterface

interface deq_rsp_if #(
  parameter int DATA_WIDTH = 32,
  parameter int OCC_WIDTH  = 5
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] out_value;
  logic [1:0]            status;
  logic                  last;
  logic [OCC_WIDTH-1:0]  occupancy;

  modport source (output valid, output out_value, output status, output last,
                  output occupancy, input ready);
  modport sink (input valid, input out_value, input status, input last,
                input occupancy, output ready);
endinterface

// ----- src/deq_cell.sv -----
module deq_cell
  import deq_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  input  logic [DATA_WIDTH-1:0] head_i,
  input  logic [DATA_WIDTH-1:0] push_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctl_i.op)
      OP_HOLD: data_nxt = data_r;
      OP_SHR:  data_nxt = left_i;
      OP_SHL:  data_nxt = right_i;
      OP_LOAD: begin
        if (ctl_i.is_cnt) data_nxt = push_i;
      end
      // The tail cell closes the ring by taking the head element.
      OP_ROTL: begin
        if (ctl_i.is_tail) begin
          data_nxt = head_i;
        end else if (ctl_i.in_occ) begin
          data_nxt = right_i;
        end
      end
      OP_ROTR: begin
        if (ctl_i.in_occ) data_nxt = left_i;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

// ----- src/double_ended_queue_unit.sv -----
// Bounded double-ended queue of CAPACITY words held in a chain of cells, cell 0
// being the front. Push, pop and peek requests are answered through the output
// register; one request per cycle is accepted while the result side keeps up,
// and each gives exactly one result word with last set. A walk gives one result
// word per stored element (one empty-status word for an empty queue); the chain
// rotates by one cell per cycle, while the result side keeps up, to bring each
// element to the output register; no request is accepted during a walk. A push
// into a full queue is dropped with a full status, and pop, peek or walk on an
// empty queue returns an empty status; error results carry a zero value.
`include "assert_macros.svh"

module double_ended_queue_unit
  import deq_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic       clk,
  input logic       rst_n,
  deq_req_if.sink   in_req,
  deq_rsp_if.source out_rsp
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             walking_r, walking_nxt;
  logic             walk_back_r, walk_back_nxt;
  logic [CNT_W-1:0] walk_left_r, walk_left_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_value_r;
  status_t               out_status_r;
  logic                  out_last_r;
  logic [CNT_W-1:0]      out_occ_r;

  logic                  slot_free;
  logic                  in_ready;
  logic                  accept;
  logic                  step;
  logic                  emit;
  logic                  empty;
  logic                  full;
  req_type_t             req;
  cell_op_t              cell_op;
  logic [DATA_WIDTH-1:0] res_value;
  status_t               res_status;
  logic                  res_last;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] head_data;
  logic [DATA_WIDTH-1:0] tail_data;
  logic [DATA_WIDTH-1:0] chain_in;
  logic [CNT_W-1:0]      tail_pos;

  assign tail_pos  = cnt_r - CNT_W'(1);
  assign head_data = cell_data[0];
  assign tail_data = cell_data[tail_pos[IDX_W-1:0]];
  assign empty     = (cnt_r == '0);
  assign full      = (cnt_r == CNT_W'(CAPACITY));
  assign req       = req_type_t'(in_req.req_type);

  always_comb begin
    slot_free     = !out_valid_r || out_rsp.ready;
    in_ready      = !walking_r && slot_free;
    accept        = in_req.valid && in_ready;
    step          = walking_r && slot_free;
    cnt_nxt       = cnt_r;
    walking_nxt   = walking_r;
    walk_back_nxt = walk_back_r;
    walk_left_nxt = walk_left_r;
    cell_op       = OP_HOLD;
    emit          = 1'b0;
    res_value     = '0;
    res_status    = ST_OK;
    res_last      = 1'b1;

    if (accept) begin
      emit = 1'b1;
      case (req)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (full) begin
            res_status = ST_FULL;
          end else begin
            cell_op = (req == REQ_PUSH_FRONT) ? OP_SHR : OP_LOAD;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_FIRST, REQ_PEEK_LAST: begin
          if (empty) begin
            res_status = ST_EMPTY;
          end else begin
            res_value = (req == REQ_POP_FRONT || req == REQ_PEEK_FIRST) ?
                        head_data : tail_data;
            if (req == REQ_POP_FRONT) cell_op = OP_SHL;
            if (req == REQ_POP_FRONT || req == REQ_POP_BACK) begin
              cnt_nxt = cnt_r - CNT_W'(1);
            end
          end
        end
        REQ_WALK_FWD, REQ_WALK_BWD: begin
          if (empty) begin
            res_status = ST_EMPTY;
          end else begin
            walk_back_nxt = (req == REQ_WALK_BWD);
            res_value     = walk_back_nxt ? tail_data : head_data;
            cell_op       = walk_back_nxt ? OP_ROTR : OP_ROTL;
            res_last      = (cnt_r == CNT_W'(1));
            walking_nxt   = !res_last;
            walk_left_nxt = cnt_r - CNT_W'(1);
          end
        end
        default: emit = 1'b1;
      endcase
    end else if (step) begin
      // One more element of a walk; the rotation brings the next one into place.
      emit          = 1'b1;
      res_value     = walk_back_r ? tail_data : head_data;
      cell_op       = walk_back_r ? OP_ROTR : OP_ROTL;
      res_last      = (walk_left_r == CNT_W'(1));
      walking_nxt   = !res_last;
      walk_left_nxt = walk_left_r - CNT_W'(1);
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // The front cell takes the pushed word on a shift and the tail word on a
  // backward rotation.
  assign chain_in = (cell_op == OP_ROTR) ? tail_data : in_req.push_value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t             ctl;
    logic [DATA_WIDTH-1:0] left_data;
    logic [DATA_WIDTH-1:0] right_data;

    assign ctl.op      = cell_op;
    assign ctl.in_occ  = (CNT_W'(i) < cnt_r);
    assign ctl.is_tail = (CNT_W'(i) == tail_pos) && !empty;
    assign ctl.is_cnt  = (CNT_W'(i) == cnt_r);

    if (i == 0) begin : g_first
      assign left_data = chain_in;
    end else begin : g_inner_l
      assign left_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_inner_r
      assign right_data = cell_data[i+1];
    end

    deq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk    (clk),
      .ctl_i  (ctl),
      .left_i (left_data),
      .right_i(right_data),
      .head_i (head_data),
      .push_i (in_req.push_value),
      .data_o (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      walking_r   <= 1'b0;
      walk_back_r <= 1'b0;
      walk_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      walking_r   <= walking_nxt;
      walk_back_r <= walk_back_nxt;
      walk_left_r <= walk_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
      out_last_r   <= res_last;
      out_occ_r    <= cnt_nxt;
    end
  end

  assign in_req.ready      = in_ready;
  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.out_value = out_value_r;
  assign out_rsp.status    = out_status_r;
  assign out_rsp.last      = out_last_r;
  assign out_rsp.occupancy = out_occ_r;

  `DEQ_NEVER(a_cnt_bound, cnt_r > CNT_W'(CAPACITY), "element count above capacity")
  `DEQ_NEVER(a_no_accept_in_walk, walking_r && in_req.ready, "request taken during a walk")
  `DEQ_ASSERT(a_walk_left, walking_r |-> (walk_left_r != '0), "walk running with nothing left")
  `DEQ_ASSERT(a_walk_end, (step && walk_left_r == CNT_W'(1)) |=> !walking_r, "walk did not end")
  `DEQ_ASSERT(a_full_push, (accept && full && (req == REQ_PUSH_FRONT || req == REQ_PUSH_BACK)) |=> (out_valid_r && out_status_r == ST_FULL && cnt_r == CNT_W'(CAPACITY)), "full push not reported")

endmodule
